>>> design/mdda_pkg.sv
// shared types, codes and sizes for the morph delta dequantize-accumulate block
`timescale 1ns / 1ps
`default_nettype none

package mdda_pkg;

  localparam int VERTICES_DEF = 4096;
  localparam int GROUP_SIZE   = 32;
  localparam int OFIFO_DEPTH  = 4;
  localparam int CFG_IW       = 3;

  // input actions
  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_HEADER = 2'd1;
  localparam logic [1:0] ACT_RECORD = 2'd2;

  // result status
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DROP = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;
  localparam logic [1:0] ST_HDR  = 2'd3;

  // register indexes
  localparam logic [CFG_IW-1:0] REG_LOWEST_X    = 3'd0;
  localparam logic [CFG_IW-1:0] REG_LOWEST_Y    = 3'd1;
  localparam logic [CFG_IW-1:0] REG_LOWEST_Z    = 3'd2;
  localparam logic [CFG_IW-1:0] REG_STEP_X      = 3'd3;
  localparam logic [CFG_IW-1:0] REG_STEP_Y      = 3'd4;
  localparam logic [CFG_IW-1:0] REG_STEP_Z      = 3'd5;
  localparam logic [CFG_IW-1:0] REG_VERTEX_COUNT = 3'd6;

  // pipeline word kinds
  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_REC  = 2'd1;
  localparam logic [1:0] KIND_HDR  = 2'd2;
  localparam logic [1:0] KIND_DROP = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic [11:0]        vertex_index;
    logic signed [31:0] base_x;
    logic signed [31:0] base_y;
    logic signed [31:0] base_z;
    logic [31:0]        presence_mask;
    logic [11:0]        group_start;
    logic [15:0]        raw_z;
    logic [7:0]         raw_y;
    logic [7:0]         raw_x;
  } in_t;

  typedef struct packed {
    logic [11:0]        out_index;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [1:0]         status;
  } out_t;

  typedef struct packed {
    logic signed [31:0] lowest_x;
    logic signed [31:0] lowest_y;
    logic signed [31:0] lowest_z;
    logic signed [31:0] step_x;
    logic signed [31:0] step_y;
    logic signed [31:0] step_z;
    logic [12:0]        vertex_count;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [11:0]        oidx;
    logic signed [31:0] base_x;
    logic signed [31:0] base_y;
    logic signed [31:0] base_z;
    logic [7:0]         lvl_x;
    logic [10:0]        lvl_y;
    logic [9:0]         lvl_z;
  } s1_t;

endpackage

`default_nettype wire

>>> design/mdda_decode.sv
// item decode, group mask tracking and target vertex selection
`timescale 1ns / 1ps
`default_nettype none

module mdda_decode import mdda_pkg::*; #(
  parameter int VERTICES = VERTICES_DEF,
  localparam int AW = $clog2(VERTICES)
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_fire,
  input  wire in_t         in_data,
  input  wire logic [12:0] vertex_count,
  output logic             s1_valid,
  output s1_t              s1,
  output logic [AW-1:0]    s1_idx
);

  localparam int GW = $clog2(GROUP_SIZE);

  logic [GROUP_SIZE-1:0] pend_mask_r, pend_mask_nxt;
  logic [11:0]           pend_start_r, pend_start_nxt;
  logic [GROUP_SIZE-1:0] hdr_mask, low_bit;
  logic [GW-1:0]         low_pos;
  logic [12:0]           rec_sum;
  logic                  s1_valid_r, s1_valid_nxt;
  s1_t                   s1_r, s1_nxt;
  logic [AW-1:0]         s1_idx_r, s1_idx_nxt;

  // header bits past the vertex count are dropped
  always_comb begin
    for (int j = 0; j < GROUP_SIZE; j++) begin
      hdr_mask[j] = in_data.presence_mask[j] &&
                    ((13'(in_data.group_start) + 13'(j)) < vertex_count);
    end
  end

  assign low_bit = pend_mask_r & (~pend_mask_r + GROUP_SIZE'(1));

  always_comb begin
    low_pos = '0;
    for (int j = 0; j < GROUP_SIZE; j++) begin
      if (low_bit[j]) begin
        low_pos = low_pos | GW'(j);
      end
    end
  end

  assign rec_sum = 13'(pend_start_r) + 13'(low_pos);

  always_comb begin
    pend_mask_nxt  = pend_mask_r;
    pend_start_nxt = pend_start_r;
    s1_valid_nxt   = in_fire;
    s1_idx_nxt     = '0;
    s1_nxt.kind    = KIND_DROP;
    s1_nxt.oidx    = '0;
    s1_nxt.base_x  = in_data.base_x;
    s1_nxt.base_y  = in_data.base_y;
    s1_nxt.base_z  = in_data.base_z;
    s1_nxt.lvl_x   = in_data.raw_x;
    s1_nxt.lvl_y   = {in_data.raw_y[4:0], in_data.raw_z[15:10]};
    s1_nxt.lvl_z   = in_data.raw_z[9:0];
    if (in_fire) begin
      unique case (in_data.action)
        ACT_LOAD: begin
          s1_nxt.kind = KIND_LOAD;
          s1_idx_nxt  = AW'(in_data.vertex_index);
          s1_nxt.oidx = 12'(AW'(in_data.vertex_index));
        end
        ACT_HEADER: begin
          s1_nxt.kind    = KIND_HDR;
          s1_nxt.oidx    = in_data.group_start;
          pend_mask_nxt  = hdr_mask;
          pend_start_nxt = in_data.group_start;
        end
        ACT_RECORD: begin
          if (pend_mask_r != '0) begin
            s1_nxt.kind   = KIND_REC;
            s1_idx_nxt    = AW'(rec_sum);
            s1_nxt.oidx   = 12'(AW'(rec_sum));
            pend_mask_nxt = pend_mask_r & ~low_bit;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_mask_r  <= '0;
      pend_start_r <= '0;
      s1_valid_r   <= 1'b0;
    end else begin
      pend_mask_r  <= pend_mask_nxt;
      pend_start_r <= pend_start_nxt;
      s1_valid_r   <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r     <= s1_nxt;
    s1_idx_r <= s1_idx_nxt;
  end

  assign s1_valid = s1_valid_r;
  assign s1       = s1_r;
  assign s1_idx   = s1_idx_r;

endmodule

`default_nettype wire

>>> design/mdda_update.sv
// dequantize, vertex store read-modify-write with forwarding, saturation
`timescale 1ns / 1ps
`default_nettype none

module mdda_update import mdda_pkg::*; #(
  parameter int VERTICES = VERTICES_DEF,
  localparam int AW = $clog2(VERTICES)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cfg_t          cfg,
  input  wire logic          s1_valid,
  input  wire s1_t           s1,
  input  wire logic [AW-1:0] s1_idx,
  output logic               push,
  output out_t               push_data
);

  localparam int PW = 48;

  typedef struct packed {
    logic [1:0]           kind;
    logic [11:0]          oidx;
    logic signed [PW-1:0] add_x;
    logic signed [PW-1:0] add_y;
    logic signed [PW-1:0] add_z;
  } s2_t;

  function automatic logic [32:0] sat32(input logic signed [PW-1:0] v);
    logic hit;
    hit = (v[PW-1:31] != {(PW-31){v[PW-1]}});
    if (!hit) begin
      return {1'b0, v[31:0]};
    end
    return {1'b1, (v[PW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF)};
  endfunction

  logic signed [40:0] prod_x;
  logic signed [43:0] prod_y;
  logic signed [42:0] prod_z;
  s2_t                s2_r, s2_nxt;
  logic               s2_valid_r;
  logic [AW-1:0]      s2_idx_r;

  logic [95:0]        mem [VERTICES];
  logic [95:0]        rd_r;
  logic               wr_en;
  logic [95:0]        wr_data;

  logic               fwd_v_r;
  logic [AW-1:0]      fwd_idx_r;
  logic [95:0]        fwd_data_r;

  logic [95:0]        old;
  logic signed [PW-1:0] sum_x, sum_y, sum_z;
  logic [32:0]        res_x, res_y, res_z;
  out_t               res;

  assign prod_x = $signed(cfg.step_x) * $signed({1'b0, s1.lvl_x});
  assign prod_y = $signed(cfg.step_y) * $signed({1'b0, s1.lvl_y});
  assign prod_z = $signed(cfg.step_z) * $signed({1'b0, s1.lvl_z});

  always_comb begin
    s2_nxt.kind = s1.kind;
    s2_nxt.oidx = s1.oidx;
    if (s1.kind == KIND_LOAD) begin
      s2_nxt.add_x = PW'(s1.base_x);
      s2_nxt.add_y = PW'(s1.base_y);
      s2_nxt.add_z = PW'(s1.base_z);
    end else begin
      // x step carries an extra factor of eight
      s2_nxt.add_x = PW'(prod_x) <<< 3;
      s2_nxt.add_y = PW'(prod_y);
      s2_nxt.add_z = PW'(prod_z);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_r     <= s2_nxt;
    s2_idx_r <= s1_idx;
  end

  // store word is {x, y, z}
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s2_idx_r] <= wr_data;
    end
    rd_r <= mem[s1_idx];
  end

  // last write lands on the same edge as the next read, so keep a copy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_v_r <= 1'b0;
    end else if (wr_en) begin
      fwd_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_idx_r  <= s2_idx_r;
      fwd_data_r <= wr_data;
    end
  end

  assign old = (fwd_v_r && (fwd_idx_r == s2_idx_r)) ? fwd_data_r : rd_r;

  assign sum_x = PW'($signed(old[95:64])) + PW'(cfg.lowest_x) + s2_r.add_x;
  assign sum_y = PW'($signed(old[63:32])) + PW'(cfg.lowest_y) + s2_r.add_y;
  assign sum_z = PW'($signed(old[31:0]))  + PW'(cfg.lowest_z) + s2_r.add_z;

  assign res_x = sat32(sum_x);
  assign res_y = sat32(sum_y);
  assign res_z = sat32(sum_z);

  always_comb begin
    res.out_index = s2_r.oidx;
    res.out_x     = '0;
    res.out_y     = '0;
    res.out_z     = '0;
    res.status    = ST_DROP;
    wr_en         = 1'b0;
    unique case (s2_r.kind)
      KIND_LOAD: begin
        res.out_x  = s2_r.add_x[31:0];
        res.out_y  = s2_r.add_y[31:0];
        res.out_z  = s2_r.add_z[31:0];
        res.status = ST_OK;
        wr_en      = s2_valid_r;
      end
      KIND_REC: begin
        res.out_x  = res_x[31:0];
        res.out_y  = res_y[31:0];
        res.out_z  = res_z[31:0];
        res.status = (res_x[32] || res_y[32] || res_z[32]) ? ST_SAT : ST_OK;
        wr_en      = s2_valid_r;
      end
      KIND_HDR: begin
        res.status = ST_HDR;
      end
      default: begin
        res.status = ST_DROP;
      end
    endcase
  end

  assign wr_data   = {res.out_x, res.out_y, res.out_z};
  assign push      = s2_valid_r;
  assign push_data = res;

endmodule

`default_nettype wire

>>> design/mdda_ofifo.sv
// small result queue between the pipeline and the output handshake
`timescale 1ns / 1ps
`default_nettype none

module mdda_ofifo import mdda_pkg::*; #(
  localparam int DW = $clog2(OFIFO_DEPTH),
  localparam int CW = $clog2(OFIFO_DEPTH + 1)
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire out_t  push_data,
  output logic       out_valid,
  input  wire logic  out_ready,
  output out_t       out_data,
  output logic [CW-1:0] count
);

  out_t          slot_r [OFIFO_DEPTH];
  logic [DW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;

  assign pop = out_valid && out_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + DW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + DW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign out_valid = (cnt_r != '0);
  assign out_data  = slot_r[rd_ptr_r];
  assign count     = cnt_r;

endmodule

`default_nettype wire

>>> design/morph_delta_dequant_accumulate_core.sv
// top level: config registers, decode, store update and result queue
//
//  port group  dir   handshake            word
//  in_*        in    in_valid/in_ready    in_t: load, group header or delta record
//  out_*       out   out_valid/out_ready  out_t: one result per input word
//  cfg_*       in    cfg_we               register index and 32-bit data
//
// one word per cycle while in_ready is high; the store read-modify-write (one read
// port, one write port, forwarding of the last write) sets that figure.
// each result passes the decode and update registers, then a queue slot.
// in_ready drops when four words are in flight or queued; the pipeline itself
// never stalls. no clearing pass after reset: store entries hold garbage until
// loaded, header state and control clear on rst_n.
`timescale 1ns / 1ps
`default_nettype none

module morph_delta_dequant_accumulate_core import mdda_pkg::*; #(
  parameter int VERTICES = VERTICES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_t               in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_t                   out_data,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [31:0]       cfg_wdata
);

  localparam int AW  = $clog2(VERTICES);
  localparam int CW  = $clog2(OFIFO_DEPTH + 1);
  localparam int CRW = CW + 1;

  cfg_t          cfg_r, cfg_nxt;
  logic          in_fire;
  logic          s1_valid;
  s1_t           s1;
  logic [AW-1:0] s1_idx;
  logic          push;
  out_t          push_data;
  logic [CW-1:0] fifo_cnt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_LOWEST_X:     cfg_nxt.lowest_x     = cfg_wdata;
        REG_LOWEST_Y:     cfg_nxt.lowest_y     = cfg_wdata;
        REG_LOWEST_Z:     cfg_nxt.lowest_z     = cfg_wdata;
        REG_STEP_X:       cfg_nxt.step_x       = cfg_wdata;
        REG_STEP_Y:       cfg_nxt.step_y       = cfg_wdata;
        REG_STEP_Z:       cfg_nxt.step_z       = cfg_wdata;
        REG_VERTEX_COUNT: cfg_nxt.vertex_count = cfg_wdata[12:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // credit check: words in both stages plus queued must leave a slot
  assign in_ready = (CRW'(fifo_cnt) + CRW'(s1_valid) + CRW'(push)) < CRW'(OFIFO_DEPTH);
  assign in_fire  = in_valid && in_ready;

  mdda_decode #(.VERTICES(VERTICES)) u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .in_data      (in_data),
    .vertex_count (cfg_r.vertex_count),
    .s1_valid     (s1_valid),
    .s1           (s1),
    .s1_idx       (s1_idx)
  );

  mdda_update #(.VERTICES(VERTICES)) u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .s1_idx    (s1_idx),
    .push      (push),
    .push_data (push_data)
  );

  mdda_ofifo u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .count     (fifo_cnt)
  );

endmodule

`default_nettype wire

>>> tb/tb.sv
// self-checking testbench for the morph delta dequantize-accumulate core
`timescale 1ns / 1ps

module tb import mdda_pkg::*;;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int STORE_DEPTH = VERTICES_DEF;
  localparam int WORD_TARGET = 1300;

  logic clk;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  morph_delta_dequant_accumulate_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // predicted block state
  cfg_t regs = '0;
  logic [31:0] coord_x [STORE_DEPTH];
  logic [31:0] coord_y [STORE_DEPTH];
  logic [31:0] coord_z [STORE_DEPTH];
  logic [31:0] group_mask = '0;
  logic [11:0] group_base = '0;

  // stimulus side: which store entries have been loaded so far
  bit written [STORE_DEPTH];

  in_t  send_queue [$];
  out_t expected_results [$];

  int issued = 0;
  int accepted = 0;
  int stim_items = 0;
  int results_seen = 0;
  int sat_seen = 0;
  int drop_seen = 0;
  int phases = 0;
  int fail_count = 0;

  bit in_taken = 1'b0;
  bit out_taken = 1'b0;
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;
  int send_gap = 0;
  int recv_stall = 0;

  // header mask with bits at or past the vertex count cleared
  function automatic logic [31:0] live_mask(logic [31:0] m, logic [11:0] start,
                                            logic [12:0] count);
    int j;
    for (j = 0; j < GROUP_SIZE; j++)
      if (int'(start) + j >= int'(count)) m[j] = 1'b0;
    return m;
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] cur, input longint d,
                                          inout bit hit);
    longint s;
    s = longint'($signed(cur)) + d;
    if (s > 64'sh7FFF_FFFF) begin
      hit = 1'b1;
      s = 64'sh7FFF_FFFF;
    end
    if (s < -64'sh8000_0000) begin
      hit = 1'b1;
      s = -64'sh8000_0000;
    end
    return s[31:0];
  endfunction

  function automatic out_t apply_word(in_t w);
    out_t r;
    longint dx;
    longint dy;
    longint dz;
    int j;
    logic [11:0] idx;
    bit hit;
    r = '0;
    hit = 1'b0;
    case (w.action)
      ACT_LOAD: begin
        idx = w.vertex_index;
        coord_x[idx] = w.base_x;
        coord_y[idx] = w.base_y;
        coord_z[idx] = w.base_z;
        r.out_index = idx;
        r.out_x = w.base_x;
        r.out_y = w.base_y;
        r.out_z = w.base_z;
        r.status = ST_OK;
      end
      ACT_HEADER: begin
        group_mask = live_mask(w.presence_mask, w.group_start, regs.vertex_count);
        group_base = w.group_start;
        r.out_index = w.group_start;
        r.status = ST_HDR;
      end
      ACT_RECORD: begin
        if (group_mask == '0) begin
          r.status = ST_DROP;
        end else begin
          j = 0;
          while (!group_mask[j]) j++;
          group_mask[j] = 1'b0;
          idx = 12'(int'(group_base) + j);
          dx = longint'($signed(regs.lowest_x)) +
               longint'($signed(regs.step_x)) * 8 * longint'(w.raw_x);
          dz = longint'($signed(regs.lowest_z)) +
               longint'($signed(regs.step_z)) * longint'(w.raw_z[9:0]);
          dy = longint'($signed(regs.lowest_y)) +
               longint'($signed(regs.step_y)) *
               (longint'(w.raw_z[15:10]) + 64 * longint'(w.raw_y[4:0]));
          coord_x[idx] = sat_add(coord_x[idx], dx, hit);
          coord_y[idx] = sat_add(coord_y[idx], dy, hit);
          coord_z[idx] = sat_add(coord_z[idx], dz, hit);
          r.out_index = idx;
          r.out_x = coord_x[idx];
          r.out_y = coord_y[idx];
          r.out_z = coord_z[idx];
          r.status = hit ? ST_SAT : ST_OK;
        end
      end
      default: r.status = ST_DROP;
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $error("%s: expected %h, actual %h", name, want, got);
    end
  endtask

  // ---------------- stimulus helpers ----------------

  function automatic logic [31:0] pick_reg();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'h7FFF_FFFF;
      1: v = 32'h8000_0000;
      2: v = '0;
      3: v = $urandom;
      default: begin
        v = $urandom_range(0, 32'h0000_FFFF);
        if ($urandom_range(0, 1) != 0) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [31:0] pick_base();
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0: v = 32'h7FFF_FFFF;
      1: v = 32'h8000_0000;
      2: v = $urandom;
      default: begin
        v = $urandom_range(0, 32'h00FF_FFFF);
        if ($urandom_range(0, 1) != 0) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [12:0] pick_count();
    case ($urandom_range(0, 7))
      0: return 13'd0;
      1: return 13'd4096;
      2: return 13'd1;
      3: return 13'($urandom_range(0, 4096));
      default: return 13'($urandom_range(32, 128));
    endcase
  endfunction

  function automatic logic [31:0] pick_mask();
    case ($urandom_range(0, 6))
      0: return 32'hFFFF_FFFF;
      1: return 32'h0000_0001 << $urandom_range(0, 31);
      2: return '0;
      3: return $urandom & $urandom;
      default: return $urandom;
    endcase
  endfunction

  // every field random so unused bits toggle too
  function automatic in_t noise_word(logic [1:0] act);
    in_t w;
    w.action = act;
    w.vertex_index = 12'($urandom);
    w.base_x = $urandom;
    w.base_y = $urandom;
    w.base_z = $urandom;
    w.presence_mask = $urandom;
    w.group_start = 12'($urandom);
    w.raw_z = 16'($urandom);
    w.raw_y = 8'($urandom);
    w.raw_x = 8'($urandom);
    return w;
  endfunction

  task automatic push_word(input in_t w);
    send_queue.insert(send_queue.size(), w);
    issued++;
    if (w.action != ACT_UNUSED) stim_items++;
    if (w.action == ACT_LOAD) written[w.vertex_index] = 1'b1;
  endtask

  task automatic send_load(input logic [11:0] idx, input logic [31:0] bx,
                           input logic [31:0] by, input logic [31:0] bz);
    in_t w;
    w = noise_word(ACT_LOAD);
    w.vertex_index = idx;
    w.base_x = bx;
    w.base_y = by;
    w.base_z = bz;
    push_word(w);
  endtask

  // loads any live vertex not yet in the store, then sends the header
  task automatic send_header(input logic [31:0] m, input logic [11:0] start,
                             output int live_bits);
    in_t w;
    logic [31:0] live;
    logic [11:0] idx;
    int j;
    live = live_mask(m, start, regs.vertex_count);
    live_bits = 0;
    for (j = 0; j < GROUP_SIZE; j++) begin
      if (live[j]) begin
        live_bits++;
        idx = 12'(int'(start) + j);
        if (!written[idx]) send_load(idx, pick_base(), pick_base(), pick_base());
      end
    end
    w = noise_word(ACT_HEADER);
    w.presence_mask = m;
    w.group_start = start;
    push_word(w);
  endtask

  task automatic send_record();
    in_t w;
    w = noise_word(ACT_RECORD);
    case ($urandom_range(0, 7))
      0: begin
        w.raw_x = '1;
        w.raw_y = '1;
        w.raw_z = '1;
      end
      1: begin
        w.raw_x = '0;
        w.raw_y = '0;
        w.raw_z = '0;
      end
      default: ;
    endcase
    push_word(w);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_LOWEST_X:     regs.lowest_x = val;
      REG_LOWEST_Y:     regs.lowest_y = val;
      REG_LOWEST_Z:     regs.lowest_z = val;
      REG_STEP_X:       regs.step_x = val;
      REG_STEP_Y:       regs.step_y = val;
      REG_STEP_Z:       regs.step_z = val;
      REG_VERTEX_COUNT: regs.vertex_count = val[12:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // sender holds off until every queued word has its result back
  task automatic drain();
    while (accepted != issued || expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic random_phase(input int len);
    int target;
    int n;
    int k;
    target = stim_items + len;
    while (stim_items < target) begin
      case ($urandom_range(0, 9))
        6: send_load(12'($urandom), pick_base(), pick_base(), pick_base());
        7: send_record();
        8: push_word(noise_word(ACT_UNUSED));
        9: send_header(pick_mask(), 12'($urandom), n);
        default: begin
          // well-formed group, sometimes cut short or overrun
          if ($urandom_range(0, 9) < 7)
            send_header(pick_mask(), 12'($urandom_range(0, 100)), n);
          else
            send_header(pick_mask(), 12'($urandom), n);
          case ($urandom_range(0, 5))
            0: if (n > 0) n = n - 1;
            1: n = n + $urandom_range(1, 2);
            default: ;
          endcase
          for (k = 0; k < n; k++) send_record();
        end
      endcase
    end
  endtask

  // ---------------- driver ----------------

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold the word until it is taken
    end else begin
      in_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (send_queue.size() > 0) begin
        in_data <= send_queue.pop_front();
        in_valid <= 1'b1;
        if ($urandom_range(0, 31) == 0) send_calm = ~send_calm;
        send_gap = send_calm ? 0 : $urandom_range(0, 12);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_taken) begin
        out_taken = 1'b0;
        if ($urandom_range(0, 31) == 0) recv_calm = ~recv_calm;
        recv_stall = recv_calm ? 0 : $urandom_range(0, 12);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------- monitor ----------------

  always @(posedge clk) begin
    out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        out_taken = 1'b1;
        results_seen++;
        if (expected_results.size() == 0) begin
          fail_count++;
          $error("result word with nothing expected: %h", out_data);
        end else begin
          want = expected_results.pop_front();
          if (want.status == ST_SAT) sat_seen++;
          if (want.status == ST_DROP) drop_seen++;
          check_field("out_index", 32'(want.out_index), 32'(out_data.out_index));
          check_field("out_x", want.out_x, out_data.out_x);
          check_field("out_y", want.out_y, out_data.out_y);
          check_field("out_z", want.out_z, out_data.out_z);
          check_field("status", 32'(want.status), 32'(out_data.status));
        end
      end
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        accepted++;
        expected_results.insert(expected_results.size(), apply_word(in_data));
      end
    end
  end

  // ---------------- sequence ----------------

  initial begin
    in_t w;
    int n;
    int len;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // registers at reset: nothing pending, count zero
    send_record();
    w = '1;
    push_word(w);
    w = '0;
    w.action = ACT_UNUSED;
    push_word(w);
    send_header(32'hFFFF_FFFF, 12'd0, n);
    send_record();
    send_load(12'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_load(12'd4095, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    drain();
    phases++;

    // extreme offsets and steps, full count; group straddles the top of the store
    write_reg(REG_LOWEST_X, 32'h7FFF_FFFF);
    write_reg(REG_LOWEST_Y, 32'h8000_0000);
    write_reg(REG_LOWEST_Z, 32'h0000_0000);
    write_reg(REG_STEP_X, 32'h7FFF_FFFF);
    write_reg(REG_STEP_Y, 32'h8000_0000);
    write_reg(REG_STEP_Z, 32'h0000_0001);
    write_reg(REG_VERTEX_COUNT, 32'd4096);
    send_load(12'd4080, 32'h7FFF_0000, 32'h7FFF_0000, 32'h7FFF_0000);
    send_header(32'h0001_8001, 12'd4080, n);
    w = noise_word(ACT_RECORD);
    w.raw_x = '1;
    w.raw_y = '1;
    w.raw_z = '1;
    push_word(w);
    w = noise_word(ACT_RECORD);
    w.raw_x = '0;
    w.raw_y = '0;
    w.raw_z = '0;
    push_word(w);
    send_record();
    send_header(32'h0000_0001, 12'd4095, n);
    send_record();
    drain();
    phases++;

    // all negative extremes, small count
    write_reg(REG_LOWEST_X, 32'h8000_0000);
    write_reg(REG_LOWEST_Y, 32'h8000_0000);
    write_reg(REG_LOWEST_Z, 32'h8000_0000);
    write_reg(REG_STEP_X, 32'h8000_0000);
    write_reg(REG_STEP_Y, 32'h8000_0000);
    write_reg(REG_STEP_Z, 32'h8000_0000);
    write_reg(REG_VERTEX_COUNT, 32'd40);
    random_phase(80);
    drain();
    phases++;

    while (issued < WORD_TARGET) begin
      write_reg(REG_LOWEST_X, pick_reg());
      write_reg(REG_LOWEST_Y, pick_reg());
      write_reg(REG_LOWEST_Z, pick_reg());
      write_reg(REG_STEP_X, pick_reg());
      write_reg(REG_STEP_Y, pick_reg());
      write_reg(REG_STEP_Z, pick_reg());
      write_reg(REG_VERTEX_COUNT, 32'(pick_count()));
      len = $urandom_range(100, 220);
      if (len > WORD_TARGET - issued) len = WORD_TARGET - issued;
      random_phase(len);
      drain();
      phases++;
    end

    repeat (10) @(negedge clk);
    $display("tb: %0d words sent over %0d register settings, %0d results checked",
             issued, phases, results_seen);
    $display("tb: %0d saturated updates, %0d dropped or unused words", sat_seen, drop_seen);
    if (fail_count == 0 && expected_results.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
